/* src/assert_macros.svh */
// Assertion helpers for the matrix inverter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg)
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

/* src/mig_pkg.sv */
package mig_pkg;
  localparam int unsigned MaxSizeDef  = 8;
  localparam int unsigned FracBitsDef = 16;
  localparam int unsigned ElemW       = 32;
  localparam int unsigned SizeW       = 4;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_INIT,
    ST_PSCAN,
    ST_PWAIT,
    ST_DIVRD,
    ST_DIVRUN,
    ST_MULRD,
    ST_MSRD,
    ST_MSMUL,
    ST_MSWR,
    ST_OUTRD,
    ST_OUTHOLD
  } mig_state_e;
endpackage

/* src/mig_if.sv */
interface mig_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] element;
  modport source (output valid, output element, input ready);
  modport sink (input valid, input element, output ready);
endinterface

interface mig_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] inverse_element;
  logic        last;
  logic        singular;
  logic        saturated;
  modport source (output valid, output inverse_element, output last, output singular,
                  output saturated, input ready);
  modport sink (input valid, input inverse_element, input last, input singular,
                input saturated, output ready);
endinterface

/* src/mig_ram.sv */
module mig_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

/* src/mig_div.sv */
// Restoring divider: quotient of (num << FracBits) / den, toward zero, saturated.
module mig_div
  import mig_pkg::*;
#(
  parameter int unsigned FracBits = FracBitsDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [ElemW-1:0] num_i,
  input  logic signed [ElemW-1:0] den_i,
  output logic                    done_o,
  output logic signed [ElemW-1:0] quo_o,
  output logic                    sat_o
);
  localparam int unsigned NumW = ElemW + FracBits;
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] n_q, n_d;
  logic [ElemW-1:0] r_q, r_d;
  logic [ElemW-1:0] dv_q, dv_d;
  logic            neg_q, neg_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [ElemW:0]  rs;
  logic [ElemW:0]  tr;
  logic [NumW:0]   mag;
  logic signed [NumW+1:0] sq;

  always_comb begin
    n_d = n_q; r_d = r_q; dv_d = dv_q; neg_d = neg_q;
    cnt_d = cnt_q; busy_d = busy_q; done_d = 1'b0;
    rs = {r_q, n_q[NumW-1]};
    tr = rs - {1'b0, dv_q};
    if (start_i) begin
      n_d = {(num_i[ElemW-1] ? ElemW'(-num_i) : ElemW'(num_i)), {FracBits{1'b0}}};
      dv_d = den_i[ElemW-1] ? ElemW'(-den_i) : ElemW'(den_i);
      neg_d = num_i[ElemW-1] ^ den_i[ElemW-1];
      r_d = '0;
      cnt_d = CntW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!tr[ElemW]) begin
        r_d = tr[ElemW-1:0];
        n_d = {n_q[NumW-2:0], 1'b1};
      end else begin
        r_d = rs[ElemW-1:0];
        n_d = {n_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d; r_q <= r_d; dv_q <= dv_d; neg_q <= neg_d;
  end

  always_comb begin
    mag = {1'b0, n_q};
    sq = neg_q ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    sat_o = 1'b0;
    quo_o = sq[ElemW-1:0];
    if (sq > $signed((NumW+2)'(32'sh7fffffff))) begin
      quo_o = 32'sh7fffffff; sat_o = 1'b1;
    end else if (sq < -$signed((NumW+2)'(33'sh080000000))) begin
      quo_o = 32'sh80000000; sat_o = 1'b1;
    end
  end
  assign done_o = done_q;
endmodule

/* src/matrix_inverse_gauss_jordan_top.sv */
// Gauss-Jordan matrix inverter with partial pivoting, signed Q16.16 by default.
// Load N*N elements row-major (N = the size written on cfg_wdata_i, 0 reads
// as 1, values above MAX_SIZE read as MAX_SIZE); one element beat is taken
// per cycle while loading. After the last beat the block builds the identity
// beside the matrix in one RAM (MAX_SIZE x 2*MAX_SIZE words), picks the
// largest-magnitude pivot per column, divides the pivot row with a bit-serial
// divider (per element: a read, a start, 48 shift steps at the default
// FRAC_BITS and the write) and clears each other row with one multiplier: a
// fetch of the row's multiplier, then a read, multiply and write step per
// element over the single RAM port pair. Row swaps go through a small row
// order table, not through data moves. A whole matrix takes N*N load beats,
// N*N identity writes, a pivot scan per column, N*(3N+1)/2 divisions, the
// elimination and N*N result beats plus receiver stalls, most of it in the
// divider. An all-zero column skips its division and elimination. The next
// matrix is taken only after the last result beat, which carries last. The
// singular flag marks an all-zero pivot column (skipped); the saturated flag
// marks any clipped intermediate. Writing the size (cfg_we_i) restarts loading.
module matrix_inverse_gauss_jordan_top
  import mig_pkg::*;
#(
  parameter int unsigned MAX_SIZE  = MaxSizeDef,
  parameter int unsigned FRAC_BITS = FracBitsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [SizeW-1:0] cfg_wdata_i,
  mig_in_if.sink           in_if,
  mig_out_if.source        out_if
);
  `include "assert_macros.svh"

  localparam int unsigned RW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int unsigned CW = RW + 1;
  localparam int unsigned AW = RW + CW;
  localparam int unsigned NW = $clog2(MAX_SIZE + 1);
  localparam logic signed [ElemW-1:0] One = ElemW'(64'd1 << FRAC_BITS);

  mig_state_e st_q, st_d;
  logic [SizeW-1:0] size_q;
  logic [NW-1:0] n;
  logic [RW-1:0] order_q [MAX_SIZE];
  logic [RW-1:0] i_q, i_d;     // logical row
  logic [CW-1:0] c_q, c_d;     // column
  logic [RW-1:0] j_q, j_d;     // pivot column
  logic [RW-1:0] br_q, br_d;
  logic [ElemW-1:0] best_q, best_d;
  logic [1:0] flags_q, flags_d;
  logic signed [ElemW-1:0] piv_q, piv_d, mult_q;
  logic signed [2*ElemW-1:0] prod_q;
  logic swap;

  logic we; logic [AW-1:0] wa, ra; logic [ElemW-1:0] wd, rd;
  logic signed [ElemW-1:0] rds;
  logic div_start, div_done, div_sat; logic signed [ElemW-1:0] div_q;
  logic [ElemW-1:0] absr;
  logic signed [2*ElemW-1:0] ms;
  logic signed [2*ElemW-1:0] fl;
  logic signed [ElemW-1:0] mss; logic mssat;

  assign n = (size_q == '0) ? NW'(1) :
             (32'(size_q) > MAX_SIZE) ? NW'(MAX_SIZE) : NW'(size_q);
  assign rds = rd;

  mig_ram #(.Width(ElemW), .Depth(1 << AW)) u_ram (
    .clk_i, .we_i(we), .waddr_i(wa), .wdata_i(wd), .raddr_i(ra), .rdata_o(rd));

  mig_div #(.FracBits(FRAC_BITS)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(rds), .den_i(piv_q),
    .done_o(div_done), .quo_o(div_q), .sat_o(div_sat));

  function automatic logic [AW-1:0] addr(logic [RW-1:0] r, logic [CW-1:0] c);
    return {r, c};
  endfunction

  // Multiply-subtract with floor shift and clip; the target word is on rd in MSWR.
  always_comb begin
    fl = prod_q >>> FRAC_BITS;
    ms = (2*ElemW)'(rds) - fl;
    mssat = 1'b0; mss = ms[ElemW-1:0];
    if (ms > 64'sh0000_0000_7fff_ffff) begin
      mssat = 1'b1; mss = 32'sh7fffffff;
    end else if (ms < -64'sh0000_0000_8000_0000) begin
      mssat = 1'b1; mss = 32'sh80000000;
    end
  end

  assign absr = rds[ElemW-1] ? ElemW'(-rds) : ElemW'(rds);

  // Next state and datapath control.
  always_comb begin
    st_d = st_q; i_d = i_q; c_d = c_q; j_d = j_q; br_d = br_q; best_d = best_q;
    flags_d = flags_q; piv_d = piv_q;
    swap = 1'b0; div_start = 1'b0;
    we = 1'b0; wa = '0; wd = '0; ra = '0;
    unique case (st_q)
      ST_LOAD: begin
        wa = addr(i_q, c_q); wd = in_if.element; we = in_if.valid;
        if (in_if.valid) begin
          if (NW'(c_q) == n - 1'b1) begin
            c_d = '0;
            if (NW'(i_q) == n - 1'b1) begin
              i_d = '0; st_d = ST_INIT;
            end else i_d = i_q + 1'b1;
          end else c_d = c_q + 1'b1;
        end
      end
      ST_INIT: begin
        we = 1'b1; wa = addr(i_q, CW'(n) + c_q);
        wd = (RW'(c_q) == i_q) ? One : '0;
        if (NW'(c_q) == n - 1'b1) begin
          c_d = '0;
          if (NW'(i_q) == n - 1'b1) begin
            i_d = '0; j_d = '0; st_d = ST_PSCAN;
          end else i_d = i_q + 1'b1;
        end else c_d = c_q + 1'b1;
        if (st_d == ST_PSCAN) begin
          i_d = '0; best_d = '0; br_d = '0;
        end
      end
      ST_PSCAN: begin
        // Issue read of row i; compare arrives next cycle.
        ra = addr(order_q[i_q], CW'(j_q));
        if (i_q == j_q) begin
          best_d = '0; br_d = j_q;
        end
        st_d = ST_PWAIT;
      end
      ST_PWAIT: begin
        if (absr > best_q) begin
          best_d = absr; br_d = i_q; piv_d = rds;
        end
        if (NW'(i_q) == n - 1'b1) begin
          if (absr > best_q || best_q != '0) begin
            swap = 1'b1; c_d = CW'(j_q); i_d = '0; st_d = ST_DIVRD;
          end else begin
            flags_d[0] = 1'b1;
            if (NW'(j_q) == n - 1'b1) begin
              i_d = '0; c_d = '0; st_d = ST_OUTRD;
            end else begin
              j_d = j_q + 1'b1; i_d = j_q + 1'b1; best_d = '0; br_d = j_q + 1'b1;
              st_d = ST_PSCAN;
            end
          end
        end else begin
          i_d = i_q + 1'b1; st_d = ST_PSCAN;
        end
      end
      ST_DIVRD: begin
        ra = addr(order_q[j_q], c_q);
        st_d = ST_DIVRUN;
      end
      ST_DIVRUN: begin
        // i marks whether the divide for this element has been started.
        div_start = (i_q == RW'(0)) && !div_done;
        if (i_q == RW'(0)) begin
          i_d = RW'(1);
        end
        if (div_done) begin
          we = 1'b1; wa = addr(order_q[j_q], c_q); wd = div_q;
          flags_d[1] = flags_q[1] | div_sat; i_d = '0;
          if (c_q == CW'(2 * n - 1)) begin
            i_d = (j_q == '0) ? RW'(1) : '0;
            st_d = (n == NW'(1)) ? ST_OUTRD : ST_MULRD;
            if (n == NW'(1)) begin
              i_d = '0; c_d = '0;
            end
          end else begin
            c_d = c_q + 1'b1; st_d = ST_DIVRD;
          end
        end
      end
      ST_MULRD: begin
        // Read multiplier (row i, column j); at rd next cycle.
        ra = addr(order_q[i_q], CW'(j_q));
        c_d = CW'(j_q);
        st_d = ST_MSRD;
      end
      ST_MSRD: begin
        // Multiplier is latched on the first pass; read pivot row element.
        ra = addr(order_q[j_q], c_q);
        st_d = ST_MSMUL;
      end
      ST_MSMUL: begin
        ra = addr(order_q[i_q], c_q);
        st_d = ST_MSWR;
      end
      ST_MSWR: begin
        we = 1'b1; wa = addr(order_q[i_q], c_q); wd = mss;
        flags_d[1] = flags_q[1] | mssat;
        if (c_q == CW'(2 * n - 1)) begin
          if (NW'(i_q) == n - 1'b1 || (NW'(i_q) == n - 2'd2 && i_q + 1'b1 == j_q)) begin
            if (NW'(j_q) == n - 1'b1) begin
              i_d = '0; c_d = '0; st_d = ST_OUTRD;
            end else begin
              j_d = j_q + 1'b1; i_d = j_q + 1'b1; best_d = '0; br_d = j_q + 1'b1;
              st_d = ST_PSCAN;
            end
          end else begin
            i_d = (i_q + 1'b1 == j_q) ? i_q + 2'd2 : i_q + 1'b1;
            st_d = ST_MULRD;
          end
        end else begin
          c_d = c_q + 1'b1; st_d = ST_MSRD;
        end
      end
      ST_OUTRD: begin
        ra = addr(order_q[i_q], CW'(n) + c_q);
        st_d = ST_OUTHOLD;
      end
      ST_OUTHOLD: begin
        if (out_if.ready) begin
          if (NW'(c_q) == n - 1'b1) begin
            c_d = '0;
            if (NW'(i_q) == n - 1'b1) begin
              i_d = '0; flags_d = '0; st_d = ST_LOAD;
            end else begin
              i_d = i_q + 1'b1; st_d = ST_OUTRD;
            end
          end else begin
            c_d = c_q + 1'b1; st_d = ST_OUTRD;
          end
        end
      end
      default: st_d = ST_LOAD;
    endcase
  end

  // Output and handshake decode.
  logic [ElemW-1:0] out_q;
  always_comb begin
    in_if.ready = (st_q == ST_LOAD) && !cfg_we_i;
    out_if.valid = (st_q == ST_OUTHOLD);
    out_if.inverse_element = out_q;
    out_if.last = (NW'(i_q) == n - 1'b1) && (NW'(c_q) == n - 1'b1);
    out_if.singular = flags_q[0];
    out_if.saturated = flags_q[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_LOAD; size_q <= SizeW'(MAX_SIZE > 15 ? 15 : MAX_SIZE);
      i_q <= '0; c_q <= '0; j_q <= '0; flags_q <= '0;
      for (int k = 0; k < MAX_SIZE; k++) order_q[k] <= RW'(k);
    end else if (cfg_we_i) begin
      size_q <= cfg_wdata_i; st_q <= ST_LOAD;
      i_q <= '0; c_q <= '0; flags_q <= '0;
    end else begin
      st_q <= st_d; i_q <= i_d; c_q <= c_d; j_q <= j_d; flags_q <= flags_d;
      if (swap && br_d != j_q) begin
        order_q[j_q] <= order_q[br_d];
        order_q[br_d] <= order_q[j_q];
      end
      if (st_q == ST_OUTHOLD && st_d == ST_LOAD) begin
        for (int k = 0; k < MAX_SIZE; k++) order_q[k] <= RW'(k);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    best_q <= best_d;
    br_q   <= br_d;
    piv_q  <= piv_d;
    // Latch the multiplier on the first column pass, then form each product.
    if (st_q == ST_MSRD && c_q == CW'(j_q)) mult_q <= rds;
    if (st_q == ST_MSMUL) prod_q <= mult_q * rds;
  end

  // Hold the result word while the receiver stalls.
  logic outrd_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) outrd_q <= 1'b0;
    else outrd_q <= (st_q == ST_OUTRD);
  end
  logic [ElemW-1:0] out_hold_q;
  always_ff @(posedge clk_i) begin
    if (outrd_q) out_hold_q <= rd;
  end
  assign out_q = outrd_q ? rd : out_hold_q;

  `ASSERT_IMPLIES(a_excl, clk_i, rst_ni, out_if.valid, !in_if.ready, "in and out overlap")
  `ASSERT_IMPLIES(a_load_nout, clk_i, rst_ni, st_q == ST_LOAD, !out_if.valid, "out in load")
  `ASSERT_IMPLIES(a_div_wr, clk_i, rst_ni, div_done, st_q == ST_DIVRUN, "stray divide")
endmodule

/* test/tb_matrix_inverse_gauss_jordan_top.sv */
module tb_matrix_inverse_gauss_jordan_top
  import mig_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_N = MaxSizeDef;
  localparam int unsigned FRAC = FracBitsDef;
  localparam int unsigned WATCHDOG_LIMIT = 200000;

  typedef struct packed {
    logic [31:0] value;
    logic        last;
    logic        singular;
    logic        saturated;
  } inv_beat_t;

  // One row of the directed table: the element and, where obvious, the result.
  typedef struct {
    logic [31:0] element;
    logic        has_known;
    logic [31:0] known_value;
    logic        known_singular;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [SizeW-1:0] cfg_wdata_i;

  mig_in_if in_if ();
  mig_out_if out_if ();

  matrix_inverse_gauss_jordan_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_if      (in_if.sink),
    .out_if     (out_if.source)
  );

  // Predictor state: its own copy of the augmented matrix and bookkeeping.
  logic signed [31:0] aug_mat [MAX_N][2*MAX_N];
  int unsigned row_map [MAX_N];
  int unsigned loaded_cnt;
  logic flag_singular;
  logic flag_saturated;
  logic [SizeW-1:0] size_reg;

  inv_beat_t inverse_queue[$];
  int unsigned fail_cnt;
  int unsigned idle_cycles;
  bit long_hold;

  function automatic int unsigned active_size();
    if (size_reg == 0) return 1;
    if (size_reg > MAX_N) return MAX_N;
    return size_reg;
  endfunction

  function automatic logic signed [31:0] clip32(longint v);
    if (v > 64'sd2147483647) begin
      flag_saturated = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -64'sd2147483648) begin
      flag_saturated = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // Run the elimination on the predictor copy and queue the inverse.
  task automatic invert_and_queue(int unsigned n);
    longint best, mag, pivot, num, prod, mult;
    int unsigned best_row, prow, qrow, tmp;
    inv_beat_t beat;
    for (int i = 0; i < MAX_N; i++) row_map[i] = i;
    for (int i = 0; i < n; i++)
      for (int c = 0; c < n; c++)
        aug_mat[i][n+c] = (i == c) ? (32'sd1 <<< FRAC) : 32'sd0;
    for (int j = 0; j < n; j++) begin
      best = 0;
      best_row = j;
      for (int i = j; i < n; i++) begin
        mag = longint'(aug_mat[row_map[i]][j]);
        if (mag < 0) mag = -mag;
        if (mag > best) begin
          best = mag;
          best_row = i;
        end
      end
      if (best == 0) begin
        flag_singular = 1'b1;
        continue;
      end
      tmp = row_map[j];
      row_map[j] = row_map[best_row];
      row_map[best_row] = tmp;
      prow = row_map[j];
      pivot = longint'(aug_mat[prow][j]);
      for (int c = j; c < 2*n; c++) begin
        num = longint'(aug_mat[prow][c]) * (64'sd1 <<< FRAC);
        aug_mat[prow][c] = clip32(num / pivot);
      end
      for (int r = 0; r < n; r++) begin
        if (r == j) continue;
        qrow = row_map[r];
        mult = longint'(aug_mat[qrow][j]);
        for (int c = j; c < 2*n; c++) begin
          prod = longint'(aug_mat[prow][c]) * mult;
          aug_mat[qrow][c] = clip32(longint'(aug_mat[qrow][c]) - (prod >>> FRAC));
        end
      end
    end
    for (int i = 0; i < n; i++)
      for (int c = 0; c < n; c++) begin
        beat.value = aug_mat[row_map[i]][n+c];
        beat.last = (i == n-1) && (c == n-1);
        beat.singular = flag_singular;
        beat.saturated = flag_saturated;
        inverse_queue.push_back(beat);
      end
    loaded_cnt = 0;
    flag_singular = 1'b0;
    flag_saturated = 1'b0;
  endtask

  task automatic absorb_element(logic [31:0] e);
    int unsigned n;
    n = active_size();
    if (loaded_cnt >= n*n) loaded_cnt = 0;
    aug_mat[loaded_cnt / n][loaded_cnt % n] = e;
    loaded_cnt++;
    if (loaded_cnt == n*n) invert_and_queue(n);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Count cycles without any beat; stop the run if the block hangs.
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t watchdog expired, %0d results outstanding", $time, inverse_queue.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // Check every accepted result beat against the oldest expectation.
  always @(posedge clk_i) begin
    inv_beat_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (inverse_queue.size() == 0) begin
        $display("%0t unexpected result beat: value %h last %b", $time,
                 out_if.inverse_element, out_if.last);
        fail_cnt++;
      end else begin
        want = inverse_queue.pop_front();
        if (want.value !== out_if.inverse_element) begin
          $display("%0t inverse_element: expected %h, got %h", $time, want.value,
                   out_if.inverse_element);
          fail_cnt++;
        end
        if (want.last !== out_if.last) begin
          $display("%0t last: expected %b, got %b", $time, want.last, out_if.last);
          fail_cnt++;
        end
        if (want.singular !== out_if.singular) begin
          $display("%0t singular: expected %b, got %b", $time, want.singular,
                   out_if.singular);
          fail_cnt++;
        end
        if (want.saturated !== out_if.saturated) begin
          $display("%0t saturated: expected %b, got %b", $time, want.saturated,
                   out_if.saturated);
          fail_cnt++;
        end
      end
    end
  end

  // Receiver: random stalls, mostly short, a few long, plus forced long holds.
  initial begin
    int unsigned gap;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        out_if.ready <= 1'b0;
        repeat (3000) @(posedge clk_i);
        long_hold = 1'b0;
      end
      case ($urandom_range(0, 9))
        0, 1: gap = $urandom_range(1, 3);
        2: gap = $urandom_range(10, 60);
        default: gap = 0;
      endcase
      if (gap == 0) begin
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= 1'b0;
        repeat (gap - 1) @(posedge clk_i);
      end
    end
  end

  // Offer one element beat, holding valid until it is taken, then maybe pause.
  task automatic send_element(logic [31:0] e, bit allow_gap);
    int unsigned gap;
    in_if.valid <= 1'b1;
    in_if.element <= e;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    absorb_element(e);
    gap = 0;
    if (allow_gap)
      case ($urandom_range(0, 9))
        0, 1: gap = $urandom_range(1, 3);
        2: gap = $urandom_range(8, 40);
        default: gap = 0;
      endcase
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (inverse_queue.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_size(logic [SizeW-1:0] sz);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= sz;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    size_reg = sz;
    loaded_cnt = 0;
    flag_singular = 1'b0;
    flag_saturated = 1'b0;
  endtask

  function automatic logic [31:0] rand_element();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom())};
      2: return 32'h0;
      3: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(0, 8 << FRAC)) - (4 << FRAC));
    endcase
  endfunction

  dir_row_t dir_table[$];

  initial begin
    dir_row_t row;
    int unsigned sz, cnt;
    fail_cnt = 0;
    idle_cycles = 0;
    long_hold = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_if.valid = 1'b0;
    in_if.element = '0;
    size_reg = MAX_N;
    loaded_cnt = 0;
    flag_singular = 1'b0;
    flag_saturated = 1'b0;
    for (int i = 0; i < MAX_N; i++) row_map[i] = i;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed 1x1 matrices: identity, zero (singular), extremes, tiny pivot.
    write_size(1);
    dir_table.push_back('{32'h0001_0000, 1'b1, 32'h0001_0000, 1'b0});
    dir_table.push_back('{32'h0000_0000, 1'b1, 32'h0001_0000, 1'b1});
    dir_table.push_back('{32'h7fff_ffff, 1'b0, 32'h0, 1'b0});
    dir_table.push_back('{32'h8000_0000, 1'b0, 32'h0, 1'b0});
    dir_table.push_back('{32'h0000_0001, 1'b0, 32'h0, 1'b0});
    dir_table.push_back('{32'hffff_ffff, 1'b0, 32'h0, 1'b0});
    dir_table.push_back('{32'hfffe_0000, 1'b1, 32'hffff_8000, 1'b0});
    foreach (dir_table[k]) begin
      row = dir_table[k];
      send_element(row.element, 1'b0);
      // Override the last prediction with the hand value where one is known.
      if (row.has_known) begin
        inverse_queue[inverse_queue.size()-1].value = row.known_value;
        inverse_queue[inverse_queue.size()-1].singular = row.known_singular;
      end
    end
    drain_results();

    // Size zero reads as one; then a 2x2 with a zero column and pivot ties.
    write_size(0);
    send_element(32'h0004_0000, 1'b0);
    drain_results();
    write_size(2);
    send_element(32'h0000_0000, 1'b0);
    send_element(32'h0001_0000, 1'b0);
    send_element(32'h0000_0000, 1'b0);
    send_element(32'h0002_0000, 1'b0);
    send_element(32'h0001_0000, 1'b0);
    send_element(32'hffff_0000, 1'b0);
    send_element(32'hffff_0000, 1'b0);
    send_element(32'h0001_0000, 1'b0);
    // Restart mid-load: the size write drops the partial matrix.
    send_element(32'h0003_0000, 1'b0);
    drain_results();
    write_size(15);

    // Random phases over several sizes, max size included; force one long hold.
    for (int ph = 0; ph < 7; ph++) begin
      case (ph % 6)
        0: sz = 15;
        1: sz = 8;
        default: sz = $urandom_range(1, 4);
      endcase
      if (ph != 0) write_size(sz);
      cnt = active_size() * active_size();
      if (ph == 3) long_hold = 1'b1;
      for (int m = 0; m < ((cnt > 20) ? 1 : (36 / cnt) + 1); m++)
        for (int e = 0; e < cnt; e++) begin
          send_element(rand_element(), 1'b1);
        end
      drain_results();
    end
    // Long hold while several small matrices are pushed.
    write_size(2);
    long_hold = 1'b1;
    for (int e = 0; e < 40; e++) send_element(rand_element(), 1'b0);
    drain_results();

    if (fail_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
